// ----- sv/frw_pkg.sv -----
package frw_pkg;

	localparam int MaxTaps      = 32;
	localparam int IdxW         = $clog2(MaxTaps);
	localparam int TapW         = $clog2(MaxTaps) + 1;
	localparam int SampleW      = 16;
	localparam int CoefW        = 18;
	localparam int CoefFracBits = 16;
	localparam int ProdW        = SampleW + CoefW;
	localparam int AccW         = ProdW + IdxW;
	localparam int QuotW        = AccW - CoefFracBits;
	localparam int InDataW      = 40;
	localparam int OutDataW     = 16;

	localparam logic ActLoad   = 1'b0;
	localparam logic ActSample = 1'b1;

	localparam logic [TapW-1:0] TapReset = TapW'(MaxTaps);

endpackage

// ----- sv/fir_filter_ring_window.sv -----
// Streaming FIR filter over a 32-entry sample ring with a 32-entry Q2.16 coefficient store.
// A load word (s_tuser 0) writes one coefficient and leaves the input open. A sample word
// (s_tuser 1) stores the sample, then runs one multiply-accumulate per tap through a
// shared 16x18 multiplier, fed from the ring and coefficient stores one read a cycle.
// A sample word runs the serial tap loop through its two pipeline stages (s1, s2) into the
// accumulator; the input reopens in the same cycle as the result is registered. Results
// sit in an output register, so the next word is accepted while a result waits. Stores
// reset to zero through per-entry valid bits; no clearing pass is needed.
module fir_filter_ring_window (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [4:0] coef_index, [22:5] coef_value, [38:23] sample_in, [39] zero
	input  logic [frw_pkg::InDataW-1:0]  s_tdata,
	// [0] action
	input  logic                         s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [15:0] filtered_sample
	output logic [frw_pkg::OutDataW-1:0] m_tdata,
	// [0] saturated
	output logic                         m_tuser,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [frw_pkg::TapW-1:0]     cfg_data
);
	import frw_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FIN} state_t;

	state_t                     state_q;
	logic [TapW-1:0]            tap_count_q;
	logic [TapW-1:0]            taps_q;
	logic [TapW-1:0]            k_q;
	logic [IdxW-1:0]            rd_idx_q;
	logic [IdxW-1:0]            wp_q;
	logic [MaxTaps-1:0]         ring_vld_q;
	logic [MaxTaps-1:0]         coef_vld_q;
	logic signed [SampleW-1:0]  ring_mem [MaxTaps];
	logic signed [CoefW-1:0]    coef_mem [MaxTaps];
	logic signed [SampleW-1:0]  samp_s1;
	logic signed [CoefW-1:0]    coef_s1;
	logic                       svld_s1;
	logic                       cvld_s1;
	logic                       v_s1;
	logic signed [ProdW-1:0]    prod_s2;
	logic                       v_s2;
	logic signed [AccW-1:0]     acc_q;
	logic                       out_valid_q;
	logic [OutDataW-1:0]        out_data_q;
	logic                       out_sat_q;

	logic                       in_acc;
	logic                       is_sample;
	logic [IdxW-1:0]            in_cidx;
	logic signed [CoefW-1:0]    in_coef;
	logic signed [SampleW-1:0]  in_samp;
	logic [TapW-1:0]            taps_eff;
	logic [IdxW-1:0]            wp_next;
	logic signed [AccW-1:0]     acc_adj;
	logic signed [QuotW-1:0]    quot;
	logic [OutDataW-1:0]        res_data;
	logic                       res_sat;
	logic                       out_free;

	assign in_cidx   = s_tdata[IdxW-1:0];
	assign in_coef   = s_tdata[IdxW+CoefW-1:IdxW];
	assign in_samp   = s_tdata[IdxW+CoefW+SampleW-1:IdxW+CoefW];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign is_sample = (s_tuser == ActSample);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;

	// clamp tap count to 1..MaxTaps and compute the next write position
	always_comb begin
		if (tap_count_q == '0) begin
			taps_eff = TapW'(1);
		end else if (tap_count_q > TapW'(MaxTaps)) begin
			taps_eff = TapW'(MaxTaps);
		end else begin
			taps_eff = tap_count_q;
		end
		wp_next = wp_q + IdxW'(1);
	end

	// round toward zero, then saturate
	always_comb begin
		acc_adj = acc_q;
		if (acc_q[AccW-1]) begin
			acc_adj = acc_q + AccW'((1 << CoefFracBits) - 1);
		end
		quot = QuotW'(acc_adj >>> CoefFracBits);
		if (quot > QuotW'(32767)) begin
			res_data = 16'h7FFF;
			res_sat  = 1'b1;
		end else if (quot < -QuotW'(32768)) begin
			res_data = 16'h8000;
			res_sat  = 1'b1;
		end else begin
			res_data = quot[OutDataW-1:0];
			res_sat  = 1'b0;
		end
	end

	// write and read the stores
	always_ff @(posedge clk) begin
		if (in_acc && is_sample) begin
			ring_mem[wp_q] <= in_samp;
		end
		if (in_acc && !is_sample) begin
			coef_mem[in_cidx] <= in_coef;
		end
		samp_s1 <= ring_mem[rd_idx_q];
		coef_s1 <= coef_mem[k_q[IdxW-1:0]];
		svld_s1 <= ring_vld_q[rd_idx_q];
		cvld_s1 <= coef_vld_q[k_q[IdxW-1:0]];
		// unwritten entries read as zero
		prod_s2 <= (svld_s1 && cvld_s1) ? ProdW'(samp_s1 * coef_s1) : '0;
	end

	// hold control state, accumulate, and register the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_count_q <= TapReset;
			taps_q      <= '0;
			k_q         <= '0;
			rd_idx_q    <= '0;
			wp_q        <= '0;
			ring_vld_q  <= '0;
			coef_vld_q  <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_sat_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tap_count_q <= cfg_data;
			end
			// load a new result word or drop the one taken
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			v_s1 <= (state_q == ST_RUN);
			v_s2 <= v_s1;
			if (v_s2) begin
				acc_q <= acc_q + AccW'(prod_s2);
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && is_sample) begin
						ring_vld_q[wp_q] <= 1'b1;
						wp_q             <= wp_next;
						taps_q           <= taps_eff;
						rd_idx_q         <= wp_next - taps_eff[IdxW-1:0];
						k_q              <= '0;
						acc_q            <= '0;
						state_q          <= ST_RUN;
					end else if (in_acc) begin
						coef_vld_q[in_cidx] <= 1'b1;
					end
				end
				ST_RUN: begin
					rd_idx_q <= rd_idx_q + IdxW'(1);
					k_q      <= k_q + TapW'(1);
					if (k_q == taps_q - TapW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_data_q  <= res_data;
						out_sat_q   <= res_sat;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_sat_q;

endmodule

// ----- sv/frw_checker.sv -----
module frw_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [frw_pkg::OutDataW-1:0] m_tdata,
	input logic                         m_tuser
);
	import frw_pkg::*;

	// hold a stalled result word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// a clipped result sits at a rail
	a_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == 16'h7FFF) || (m_tdata == 16'h8000))
		else $error("saturated flag without rail value");

	// a load word gives no result
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ActLoad) |=> !$rose(m_tvalid))
		else $error("result after load word");

	// a sample word occupies the filter
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ActSample) |=> !s_tready)
		else $error("input ready during tap loop");

endmodule

bind fir_filter_ring_window frw_checker u_frw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ----- tb/fir_filter_ring_window_tb.sv -----
`timescale 1ns / 100ps

module fir_filter_ring_window_tb;
	import frw_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// [4:0] coef_index, [22:5] coef_value, [38:23] sample_in, [39] zero
	logic [InDataW-1:0]    s_tdata;
	// [0] action
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// [15:0] filtered_sample
	logic [OutDataW-1:0]   m_tdata;
	// [0] saturated
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [TapW-1:0]       cfg_data;

	typedef struct packed {
		logic [15:0] sample;
		logic        clip;
	} filt_out_t;

	// predictor state
	logic signed [SampleW-1:0] ring_copy [MaxTaps];
	logic signed [CoefW-1:0]   coef_copy [MaxTaps];
	logic [IdxW-1:0]           wr_pos;
	logic [TapW-1:0]           taps_setting;

	filt_out_t filt_expected [$];
	int        mismatch_cnt;
	int        words_sent;
	int        results_seen;
	int        sat_seen;
	int        send_idle_pct;
	int        recv_stall_pct;
	bit        hold_off;

	fir_filter_ring_window i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// compute the filter output for one sample word and update the ring
	function automatic filt_out_t filter_sample(logic signed [SampleW-1:0] smp);
		int unsigned      n;
		int unsigned      idx;
		longint           acc;
		longint           q;
		filt_out_t        r;
		ring_copy[wr_pos] = smp;
		wr_pos = wr_pos + 1'b1;
		n = taps_setting;
		if (n == 0) n = 1;
		if (n > MaxTaps) n = MaxTaps;
		idx = (int'(wr_pos) + MaxTaps - n) % MaxTaps;
		acc = 0;
		for (int k = 0; k < n; k++) begin
			acc += longint'(ring_copy[idx]) * longint'(coef_copy[k]);
			idx = (idx + 1) % MaxTaps;
		end
		// truncate toward zero
		if (acc < 0) q = -((-acc) >>> CoefFracBits);
		else q = acc >>> CoefFracBits;
		r.clip = 1'b0;
		if (q > 32767) begin
			q = 32767;
			r.clip = 1'b1;
		end else if (q < -32768) begin
			q = -32768;
			r.clip = 1'b1;
		end
		r.sample = q[15:0];
		return r;
	endfunction

	// send one word and update the prediction on acceptance; valid stays up
	// so that the next word can follow without a gap
	task automatic send_word(logic act, logic [4:0] cidx, logic [17:0] cval, logic [15:0] smp);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {1'b0, smp, cval, cidx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (act == ActLoad) coef_copy[cidx] = cval;
		else filt_expected.push_back(filter_sample(smp));
		words_sent++;
	endtask

	// drop input valid after a burst of words
	task automatic drop_valid();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_coef(int i, int v);
		send_word(ActLoad, i[4:0], v[17:0], 16'($urandom));
	endtask

	task automatic push_sample(int v);
		send_word(ActSample, 5'($urandom), 18'($urandom), v[15:0]);
	endtask

	// wait for drain, then write tap_count while idle
	task automatic set_taps(logic [TapW-1:0] n);
		drop_valid();
		while (filt_expected.size() != 0) @(posedge clk);
		repeat (MaxTaps + 10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= n;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		taps_setting = n;
		cfg_valid <= 1'b0;
	endtask

	// receiver: random stall and long hold-off
	always @(posedge clk) begin
		if (hold_off) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// check each accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (filt_expected.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected result word %h sat %b", m_tdata, m_tuser);
			end else begin
				filt_out_t e;
				e = filt_expected.pop_front();
				if (e.clip) sat_seen++;
				if (m_tdata !== e.sample || m_tuser !== e.clip) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch: expected %h sat %b, got %h sat %b",
							e.sample, e.clip, m_tdata, m_tuser);
				end
			end
		end
	end

	task automatic test_directed_extremes();
		load_coef(31, 131071);
		load_coef(0, -131072);
		load_coef(5, 65536);
		push_sample(32767);
		push_sample(-32768);
		push_sample(0);
		push_sample(-1);
		push_sample(1);
		for (int i = 0; i < 32; i++) load_coef(i, 131071);
		push_sample(32767);
		push_sample(32767);
		for (int i = 0; i < 32; i++) load_coef(i, -131072);
		push_sample(32767);
		push_sample(-32768);
	endtask

	task automatic test_tap_settings();
		logic [TapW-1:0] tap_list [6] = '{6'd1, 6'd0, 6'd63, 6'd33, 6'd2, 6'd32};
		for (int c = 0; c < 32; c++) load_coef(c, $urandom_range(131071) - 65536);
		foreach (tap_list[t]) begin
			set_taps(tap_list[t]);
			repeat (8) push_sample($urandom_range(65535) - 32768);
		end
	endtask

	task automatic run_random(int n, int idle_s, int stall_r);
		send_idle_pct  = idle_s;
		recv_stall_pct = stall_r;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 15)
				send_word(ActLoad, 5'($urandom), 18'($urandom), 16'($urandom));
			else if ($urandom_range(9) == 0)
				push_sample($urandom_range(1) ? 32767 : -32768);
			else
				send_word(ActSample, 5'($urandom), 18'($urandom), 16'($urandom));
		end
		drop_valid();
	endtask

	task automatic test_random_phases();
		run_random(180, 0, 0);
		set_taps(6'($urandom_range(1, 31)));
		run_random(180, 63, 0);
		set_taps(6'($urandom_range(1, 31)));
		run_random(180, 0, 63);
		set_taps(6'd32);
		run_random(180, 8, 8);
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			run_random(40, 0, 0);
		join
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatch_cnt = 0;
		words_sent = 0;
		results_seen = 0;
		sat_seen = 0;
		foreach (ring_copy[i]) ring_copy[i] = '0;
		foreach (coef_copy[i]) coef_copy[i] = '0;
		wr_pos = '0;
		taps_setting = TapReset;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_tap_settings();
		test_random_phases();
		test_backpressure();

		drop_valid();
		while (filt_expected.size() != 0) @(posedge clk);
		repeat (MaxTaps + 10) @(posedge clk);
		$display("sent %0d words, checked %0d results (%0d clipped)",
			words_sent, results_seen, sat_seen);
		$display("tap settings 0..63 incl. extremes, idle/stall phases and long hold-off");
		if (mismatch_cnt == 0 && filt_expected.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// timeout
	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
